/* rtl/core/bffa_pkg.sv */
package bffa_pkg;

  localparam int MAP_BITS  = 8192;
  localparam int WORD_BITS = 64;
  localparam int MAP_WORDS = MAP_BITS / WORD_BITS;
  localparam int BIT_AW    = $clog2(WORD_BITS);
  localparam int WORD_AW   = $clog2(MAP_WORDS);
  localparam int NUM_W     = 14;

  localparam logic [NUM_W-1:0] MAP_BITS_N = NUM_W'(MAP_BITS);
  localparam logic [NUM_W-1:0] COUNT_MAX  = {NUM_W{1'b1}};

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  typedef enum logic {
    KIND_ALLOC = 1'b0,
    KIND_FREE  = 1'b1
  } kind_t;

  typedef struct packed {
    logic             kind;
    logic [NUM_W-1:0] number;
  } in_beat_t;

  typedef struct packed {
    status_t          status;
    logic [NUM_W-1:0] allocated;
    logic [NUM_W-1:0] used_count;
  } out_beat_t;

  typedef struct packed {
    logic                 we;
    logic [WORD_AW-1:0]   waddr;
    logic [WORD_BITS-1:0] wdata;
    logic                 re;
    logic [WORD_AW-1:0]   raddr;
  } ram_req_t;

endpackage

/* rtl/core/bffa_ram.sv */
module bffa_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/core/bffa_scan.sv */
module bffa_scan (
  input  logic [bffa_pkg::WORD_BITS-1:0] free_bits,
  output logic                           found,
  output logic [bffa_pkg::BIT_AW-1:0]    idx
);

  import bffa_pkg::*;

  logic [WORD_BITS-1:0] lowest;

  // isolate the lowest set bit, then encode the one-hot word
  assign lowest = free_bits & (~free_bits + WORD_BITS'(1));
  assign found  = |free_bits;

  always_comb begin
    idx = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (lowest[i]) begin
        idx = idx | BIT_AW'(i);
      end
    end
  end

endmodule

/* rtl/core/bffa_seq.sv */
module bffa_seq (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  bffa_pkg::in_beat_t             in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output bffa_pkg::out_beat_t            out_data,
  input  logic                           cfg_we,
  input  logic [bffa_pkg::NUM_W-1:0]     cfg_wdata,
  output bffa_pkg::ram_req_t             ram_req,
  input  logic [bffa_pkg::WORD_BITS-1:0] ram_rdata
);

  import bffa_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_FREE_RD,
    S_FREE_WR,
    S_DONE
  } state_t;

  state_t               state_r;
  logic [NUM_W-1:0]     limit_r;
  logic [NUM_W-1:0]     lim_r;
  logic [NUM_W-1:0]     number_r;
  logic [WORD_AW:0]     issue_w_r;
  logic                 chk_v_r;
  logic [WORD_AW-1:0]   chk_w_r;
  logic [MAP_WORDS-1:0] valid_r;
  logic                 vld_rd_r;
  logic [NUM_W-1:0]     in_use_r;
  out_beat_t            res_r;
  logic                 out_valid_r;
  out_beat_t            out_data_r;

  logic [NUM_W-1:0]     eff_lim;
  logic [WORD_BITS-1:0] word;
  logic [NUM_W-1:0]     base;
  logic [NUM_W-1:0]     rem;
  logic [NUM_W-1:0]     next_base;
  logic                 last_word;
  logic [WORD_BITS-1:0] lim_mask;
  logic [WORD_BITS-1:0] free_bits;
  logic                 scan_found;
  logic [BIT_AW-1:0]    scan_idx;
  logic [NUM_W-1:0]     fidx;
  logic [WORD_AW-1:0]   f_word;
  logic [BIT_AW-1:0]    f_bit;
  logic [NUM_W-1:0]     cnt_inc;
  logic [NUM_W-1:0]     cnt_dec;

  assign eff_lim = (limit_r > MAP_BITS_N) ? MAP_BITS_N : limit_r;

  // a word never written since reset reads as all free
  assign word = vld_rd_r ? ram_rdata : '0;

  assign base      = NUM_W'({chk_w_r, {BIT_AW{1'b0}}});
  assign rem       = lim_r - base;
  assign next_base = NUM_W'({({1'b0, chk_w_r} + (WORD_AW+1)'(1)), {BIT_AW{1'b0}}});
  assign last_word = (next_base >= lim_r) || (chk_w_r == WORD_AW'(MAP_WORDS - 1));
  assign lim_mask  = (rem >= NUM_W'(WORD_BITS)) ? '1
                   : ((WORD_BITS'(1) << rem[BIT_AW-1:0]) - WORD_BITS'(1));
  assign free_bits = ~word & lim_mask;

  bffa_scan u_scan (
    .free_bits (free_bits),
    .found     (scan_found),
    .idx       (scan_idx)
  );

  assign fidx   = number_r - NUM_W'(1);
  assign f_word = fidx[BIT_AW +: WORD_AW];
  assign f_bit  = fidx[BIT_AW-1:0];

  assign cnt_inc = (in_use_r < COUNT_MAX) ? in_use_r + NUM_W'(1) : in_use_r;
  assign cnt_dec = (in_use_r != '0) ? in_use_r - NUM_W'(1) : in_use_r;

  always_comb begin
    ram_req       = '0;
    ram_req.waddr = chk_w_r;
    ram_req.raddr = issue_w_r[WORD_AW-1:0];
    ram_req.wdata = word | (WORD_BITS'(1) << scan_idx);
    case (state_r)
      S_SCAN: begin
        ram_req.re = !issue_w_r[WORD_AW];
        ram_req.we = chk_v_r && scan_found;
      end
      S_FREE_RD: begin
        ram_req.re    = 1'b1;
        ram_req.raddr = f_word;
      end
      S_FREE_WR: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = f_word;
        ram_req.wdata = word & ~(WORD_BITS'(1) << f_bit);
      end
      default: begin
      end
    endcase
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      limit_r     <= MAP_BITS_N;
      valid_r     <= '0;
      in_use_r    <= '0;
      out_valid_r <= 1'b0;
      chk_v_r     <= 1'b0;
      issue_w_r   <= '0;
    end else begin
      if (cfg_we) begin
        limit_r <= cfg_wdata;
      end
      if (ram_req.re) begin
        vld_rd_r <= valid_r[ram_req.raddr];
      end
      if (ram_req.we) begin
        valid_r[ram_req.waddr] <= 1'b1;
      end
      // in S_DONE the state machine below decides the output valid
      if (out_valid_r && out_ready && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            lim_r          <= eff_lim;
            number_r       <= in_data.number;
            issue_w_r      <= '0;
            chk_v_r        <= 1'b0;
            res_r.allocated  <= '0;
            res_r.used_count <= in_use_r;
            if (in_data.kind == KIND_ALLOC) begin
              if (eff_lim == '0) begin
                res_r.status <= ST_FULL;
                state_r      <= S_DONE;
              end else begin
                state_r <= S_SCAN;
              end
            end else if (in_data.number == '0 || in_data.number > eff_lim) begin
              res_r.status <= ST_RANGE;
              state_r      <= S_DONE;
            end else begin
              state_r <= S_FREE_RD;
            end
          end
        end
        S_SCAN: begin
          // keep one read in flight, check the word returned last cycle
          chk_v_r <= ram_req.re;
          chk_w_r <= issue_w_r[WORD_AW-1:0];
          if (ram_req.re) begin
            issue_w_r <= issue_w_r + (WORD_AW+1)'(1);
          end
          if (chk_v_r) begin
            if (scan_found) begin
              res_r.status     <= ST_OK;
              res_r.allocated  <= NUM_W'({chk_w_r, scan_idx}) + NUM_W'(1);
              res_r.used_count <= cnt_inc;
              in_use_r         <= cnt_inc;
              state_r          <= S_DONE;
            end else if (last_word) begin
              res_r.status <= ST_FULL;
              state_r      <= S_DONE;
            end
          end
        end
        S_FREE_RD: begin
          state_r <= S_FREE_WR;
        end
        S_FREE_WR: begin
          res_r.status     <= ST_OK;
          res_r.used_count <= cnt_dec;
          in_use_r         <= cnt_dec;
          state_r          <= S_DONE;
        end
        S_DONE: begin
          // hold the result until the output register frees up
          if (!out_valid_r || out_ready) begin
            out_data_r  <= res_r;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* rtl/core/bitmap_first_free_allocator_unit.sv */
// First-fit allocation bitmap of 8192 entries, one-based entry numbers.
// Input channel (in_valid/in_ready, in_data): kind 0 allocates the lowest
// free entry up to the limit, kind 1 frees entry number 1..limit. Every
// request beat yields exactly one result beat on the output channel
// (out_valid/out_ready, out_data): status, allocated number and used count.
// cfg_we/cfg_wdata write the limit register; write it only while idle.
// A free passes through S_FREE_RD, S_FREE_WR and S_DONE. An allocate scans
// the 64-bit map words in order in S_SCAN until a free entry is found or the
// limit is reached; the single read port of the map memory delivers one
// word per cycle. A request out of range or with limit zero goes to S_DONE.
// One request is in flight at a time; in_ready returns once the result has
// moved into the output register, so a new request may be accepted while
// the previous result still waits for out_ready. A stalled receiver holds
// the next result in the block, and in_ready stays low until it drains.
// Reset (rst_n low, synchronous) marks every map word free through per-word
// valid bits, zeroes the used count and sets the limit to 8192; no clearing
// pass is needed, so requests are taken right after reset.
module bitmap_first_free_allocator_unit (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  bffa_pkg::in_beat_t         in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output bffa_pkg::out_beat_t        out_data,
  input  logic                       cfg_we,
  input  logic [bffa_pkg::NUM_W-1:0] cfg_wdata
);

  import bffa_pkg::*;

  ram_req_t             ram_req;
  logic [WORD_BITS-1:0] ram_rdata;

  bffa_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .ram_req   (ram_req),
    .ram_rdata (ram_rdata)
  );

  bffa_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (MAP_WORDS)
  ) u_map (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .re    (ram_req.re),
    .raddr (ram_req.raddr),
    .rdata (ram_rdata)
  );

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while another is in flight");

  a_fail_no_number: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ST_OK |-> out_data.allocated == '0)
    else $error("failed request returned an entry number");

  a_alloc_counts: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.allocated != '0 |-> out_data.used_count != '0)
    else $error("allocation left used count at zero");

  a_alloc_in_map: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.allocated <= MAP_BITS_N)
    else $error("allocated entry beyond map");

endmodule

/* tb/tb.sv */
`timescale 1ns / 100ps

module tb;
  import bffa_pkg::*;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_beat_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_beat_t out_data;
  logic      cfg_we;
  logic [NUM_W-1:0] cfg_wdata;

  bitmap_first_free_allocator_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // shadow of the allocation map, used count and limit register
  logic [MAP_BITS-1:0] map_used;
  logic [NUM_W-1:0]    used_total;
  logic [NUM_W-1:0]    limit_reg;

  in_beat_t  alloc_requests[$];
  out_beat_t predicted_replies[$];
  int        requests_issued;
  int        replies_matched;
  int        err_count;

  logic      in_taken;
  int        burst_left;
  int        gap_left;
  int        stall_left;
  int        stall_pct;
  int        ready_cycles;
  out_beat_t want;

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    map_used = '0;
    used_total = '0;
    limit_reg = MAP_BITS_N;
    requests_issued = 0;
    replies_matched = 0;
    err_count = 0;
    in_taken = 1'b0;
    burst_left = 8;
    gap_left = 0;
    stall_left = 0;
    stall_pct = 0;
    ready_cycles = 0;
  end

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic out_beat_t predict_reply(in_beat_t req);
    out_beat_t        r;
    logic [NUM_W-1:0] eff;
    int               slot;
    eff = (limit_reg > MAP_BITS_N) ? MAP_BITS_N : limit_reg;
    r.status = ST_OK;
    r.allocated = '0;
    if (req.kind == KIND_ALLOC) begin
      slot = -1;
      for (int i = 0; i < int'(eff) && slot < 0; i++)
        if (!map_used[i]) slot = i;
      if (slot >= 0) begin
        map_used[slot] = 1'b1;
        r.allocated = NUM_W'(slot + 1);
        if (used_total != COUNT_MAX) used_total++;
      end else begin
        r.status = ST_FULL;
      end
    end else if (req.number == 0 || req.number > eff) begin
      r.status = ST_RANGE;
    end else begin
      // clearing an already clear entry still lowers the count
      map_used[req.number - 1] = 1'b0;
      if (used_total != 0) used_total--;
    end
    r.used_count = used_total;
    return r;
  endfunction

  // request driver: bursts with random gaps, payload held until accepted
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_taken) begin
      // hold the beat
    end else if (gap_left > 0) begin
      gap_left--;
      in_valid <= 1'b0;
    end else if (alloc_requests.size() > 0) begin
      in_data <= alloc_requests.pop_front();
      in_valid <= 1'b1;
      if (burst_left > 1) begin
        burst_left--;
      end else begin
        burst_left = $urandom_range(1, 24);
        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      end
    end else begin
      in_valid <= 1'b0;
    end
  end

  // result receiver: random stalls at a stall rate redrawn from four levels
  always @(negedge clk) begin
    ready_cycles++;
    if (ready_cycles % 400 == 0) begin
      case ($urandom_range(0, 3))
        0: stall_pct = 0;
        1: stall_pct = 10;
        2: stall_pct = 35;
        default: stall_pct = 70;
      endcase
    end
    if (!rst_n) begin
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if ($urandom_range(0, 99) < stall_pct) stall_left = $urandom_range(1, 12);
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_valid && in_ready;
      if (in_valid && in_ready) predicted_replies.push_back(predict_reply(in_data));
      if (out_valid && out_ready) begin
        if (predicted_replies.size() == 0) begin
          $error("result beat with no request outstanding");
          err_count++;
        end else begin
          want = predicted_replies.pop_front();
          if (out_data.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_data.status);
            err_count++;
          end
          if (out_data.allocated !== want.allocated) begin
            $error("allocated: expected %0d, got %0d", want.allocated, out_data.allocated);
            err_count++;
          end
          if (out_data.used_count !== want.used_count) begin
            $error("used_count: expected %0d, got %0d", want.used_count,
                   out_data.used_count);
            err_count++;
          end
          replies_matched++;
        end
      end
    end
  end

  task automatic queue_req(kind_t kind, int number);
    in_beat_t b;
    b.kind = kind;
    b.number = NUM_W'(number);
    alloc_requests.push_back(b);
    requests_issued++;
  endtask

  task automatic wait_drained();
    while (replies_matched != requests_issued) @(negedge clk);
  endtask

  task automatic write_limit(int value);
    wait_drained();
    repeat (6) @(negedge clk);
    cfg_wdata <= NUM_W'(value);
    cfg_we <= 1'b1;
    limit_reg = NUM_W'(value);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic queue_random(int count);
    int eff;
    int r;
    eff = (limit_reg > MAP_BITS_N) ? MAP_BITS : int'(limit_reg);
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 55) begin
        queue_req(KIND_ALLOC, $urandom_range(0, 16383));
      end else if (r < 90 && eff > 0) begin
        // favor the low region where allocations actually land
        if ($urandom_range(0, 1) == 0)
          queue_req(KIND_FREE, $urandom_range(1, (eff < 256) ? eff : 256));
        else
          queue_req(KIND_FREE, $urandom_range(1, eff));
      end else begin
        queue_req(KIND_FREE, $urandom_range(0, 16383));
      end
    end
  endtask

  initial begin
    int phase_limit[10];
    phase_limit = '{1, 64, 65, 8192, 16383, 200, 0, 8192, 128, 0};
    phase_limit[6] = $urandom_range(1, 8192);
    phase_limit[9] = $urandom_range(200, 8192);

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // default limit: basic allocate/free, range edges, count floor
    queue_req(KIND_ALLOC, 0);
    queue_req(KIND_ALLOC, 16383);
    queue_req(KIND_ALLOC, 5);
    queue_req(KIND_FREE, 2);
    queue_req(KIND_ALLOC, 0);
    queue_req(KIND_FREE, 0);
    queue_req(KIND_FREE, 8192);
    queue_req(KIND_FREE, 8193);
    queue_req(KIND_FREE, 16383);
    queue_req(KIND_FREE, 2);
    queue_req(KIND_FREE, 2);
    queue_req(KIND_FREE, 1);
    queue_req(KIND_FREE, 3);
    queue_req(KIND_FREE, 3);
    queue_req(KIND_ALLOC, 0);

    // zero limit: nothing can be allocated or freed
    write_limit(0);
    queue_req(KIND_ALLOC, 0);
    queue_req(KIND_FREE, 1);

    // limit past the map size clamps to the map
    write_limit(16383);
    queue_req(KIND_FREE, 8192);
    queue_req(KIND_FREE, 8193);
    queue_req(KIND_ALLOC, 0);

    // tiny limit: fill up, hit full, free and refill
    write_limit(3);
    queue_req(KIND_ALLOC, 0);
    queue_req(KIND_ALLOC, 0);
    queue_req(KIND_ALLOC, 0);
    queue_req(KIND_FREE, 4);
    queue_req(KIND_FREE, 3);
    queue_req(KIND_ALLOC, 0);

    foreach (phase_limit[p]) begin
      write_limit(phase_limit[p]);
      queue_random(153);
    end

    wait_drained();
    repeat (140) @(posedge clk);
    if (predicted_replies.size() != 0) begin
      $error("%0d expected results never arrived", predicted_replies.size());
      err_count++;
    end
    if (err_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

  initial begin
    #20_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

/* files.f */
rtl/core/bffa_pkg.sv
rtl/core/bffa_ram.sv
rtl/core/bffa_scan.sv
rtl/core/bffa_seq.sv
rtl/core/bitmap_first_free_allocator_unit.sv
tb/tb.sv
